// ===== hdl/xs128_pkg.sv =====
// Shared types, constants and codes of the xorshift128 generator with range.
package xs128_pkg;

    localparam int WORD_W = 32;
    localparam int CNT_W  = $clog2(WORD_W);

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [1:0]        mode_t;
    typedef logic [1:0]        cfg_idx_t;
    typedef logic [CNT_W-1:0]  bit_cnt_t;

    localparam mode_t MODE_RAW   = 2'd0;
    localparam mode_t MODE_BIT   = 2'd1;
    localparam mode_t MODE_RANGE = 2'd2;

    localparam cfg_idx_t CFG_SEED_NEWEST = 2'd0;
    localparam cfg_idx_t CFG_SEED_SECOND = 2'd1;
    localparam cfg_idx_t CFG_SEED_THIRD  = 2'd2;
    localparam cfg_idx_t CFG_SEED_OLDEST = 2'd3;

    localparam word_t SEED_NEWEST_RST = 32'd88675123;
    localparam word_t SEED_SECOND_RST = 32'd521288629;
    localparam word_t SEED_THIRD_RST  = 32'd362436069;
    localparam word_t SEED_OLDEST_RST = 32'd123456789;

    localparam int SHIFT_A = 11;
    localparam int SHIFT_B = 8;
    localparam int SHIFT_C = 19;

    // Status from the serial remainder unit
    typedef struct packed {
        logic busy;
        logic done;
    } rem_status_t;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_DONE = 3'b100
    } ctl_state_t;

endpackage

// ===== hdl/xs128_if.sv =====
// Request and response channel interfaces of the generator.
interface xs128_req_if;
    logic               valid;
    logic               ready;
    xs128_pkg::mode_t   mode;
    xs128_pkg::word_t   low_bound;
    xs128_pkg::word_t   high_bound;

    modport source (output valid, output mode, output low_bound, output high_bound,
                    input ready);
    modport sink   (input valid, input mode, input low_bound, input high_bound,
                    output ready);
endinterface

interface xs128_rsp_if;
    logic               valid;
    logic               ready;
    xs128_pkg::word_t   value;
    logic               zero_span;

    modport source (output valid, output value, output zero_span, input ready);
    modport sink   (input valid, input value, input zero_span, output ready);
endinterface

// ===== hdl/xs128_gen.sv =====
// Xorshift128 state words, seed loading and one-step advance.
module xs128_gen (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  xs128_pkg::cfg_idx_t cfg_index,
    input  xs128_pkg::word_t  cfg_data,
    input  logic              advance,
    output xs128_pkg::word_t  word_next
);
    import xs128_pkg::*;

    word_t newest_reg;
    word_t second_reg;
    word_t third_reg;
    word_t oldest_reg;
    word_t mix_a;
    word_t mix_b;

    always_comb
    begin
        mix_a     = oldest_reg ^ (oldest_reg << SHIFT_A);
        mix_b     = mix_a ^ (mix_a >> SHIFT_B);
        word_next = mix_b ^ newest_reg ^ (newest_reg >> SHIFT_C);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            newest_reg <= SEED_NEWEST_RST;
            second_reg <= SEED_SECOND_RST;
            third_reg  <= SEED_THIRD_RST;
            oldest_reg <= SEED_OLDEST_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SEED_NEWEST: newest_reg <= cfg_data;
                CFG_SEED_SECOND: second_reg <= cfg_data;
                CFG_SEED_THIRD:  third_reg  <= cfg_data;
                CFG_SEED_OLDEST: oldest_reg <= cfg_data;
                default:         newest_reg <= newest_reg;
            endcase
        end
        else if (advance)
        begin
            // shift the window down one word
            oldest_reg <= third_reg;
            third_reg  <= second_reg;
            second_reg <= newest_reg;
            newest_reg <= word_next;
        end
    end

endmodule

// ===== hdl/xs128_rem.sv =====
// Bit-serial restoring remainder: one dividend bit per cycle.
module xs128_rem (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  xs128_pkg::word_t      dividend,
    input  xs128_pkg::word_t      divisor,
    output xs128_pkg::word_t      remainder,
    output xs128_pkg::rem_status_t status
);
    import xs128_pkg::*;

    word_t    rem_reg;
    word_t    dvd_reg;
    word_t    dsr_reg;
    bit_cnt_t cnt_reg;
    logic     busy_reg;
    logic     done_reg;

    logic [WORD_W:0] trial;
    logic [WORD_W:0] diff;
    word_t           rem_next;

    always_comb
    begin
        trial    = {rem_reg, dvd_reg[WORD_W-1]};
        diff     = trial - {1'b0, dsr_reg};
        // keep the trial when the subtraction borrows
        rem_next = diff[WORD_W] ? trial[WORD_W-1:0] : diff[WORD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == bit_cnt_t'(WORD_W - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == bit_cnt_t'(WORD_W - 1))
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvd_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[WORD_W-2:0], 1'b0};
        end
    end

    assign remainder   = rem_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

    ap_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg) else $error("remainder start while busy");
    ap_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg)) else $error("done without a running division");
    ap_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (rem_reg < dsr_reg)) else $error("remainder not below divisor");

endmodule

// ===== hdl/xorshift128_prng_with_range.sv =====
// Raw, bit and zero-span requests go from accept to the done state, then to the output.
// A nonzero span adds the divide state; a new request is taken only back in idle.
// The divide waits on the bit-serial remainder unit, one dividend bit per cycle.
// A finished result waits in the output register while the next request is taken.
// Reset loads the four state words with their seed reset values; no clearing pass.
module xorshift128_prng_with_range (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  xs128_pkg::cfg_idx_t cfg_index,
    input  xs128_pkg::word_t    cfg_data,
    xs128_req_if.sink           req,
    xs128_rsp_if.source         rsp
);
    import xs128_pkg::*;

    ctl_state_t  state_reg;
    ctl_state_t  state_next;
    word_t       res_reg;
    word_t       res_next;
    logic        flag_reg;
    logic        flag_next;
    word_t       out_value_reg;
    logic        out_flag_reg;
    logic        out_valid_reg;

    logic        accept;
    logic        div_start;
    logic        out_load;
    word_t       rand_word;
    word_t       span;
    word_t       remainder;
    rem_status_t rem_st;

    xs128_gen u_gen (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (accept),
        .word_next (rand_word)
    );

    xs128_rem u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (rand_word),
        .divisor   (span),
        .remainder (remainder),
        .status    (rem_st)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign span      = req.high_bound - req.low_bound;
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        state_next = state_reg;
        res_next   = res_reg;
        flag_next  = flag_reg;
        div_start  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    flag_next  = 1'b0;
                    state_next = S_DONE;
                    case (req.mode)
                        MODE_BIT:
                            res_next = {{(WORD_W-1){1'b0}}, rand_word[0]};
                        MODE_RANGE:
                        begin
                            // hold low_bound; the remainder is added when it is ready
                            res_next = req.low_bound;
                            if (span == '0)
                                flag_next = 1'b1;
                            else
                            begin
                                div_start  = 1'b1;
                                state_next = S_DIV;
                            end
                        end
                        default:
                            res_next = rand_word;
                    endcase
                end
            end
            S_DIV:
            begin
                if (rem_st.done)
                begin
                    res_next   = res_reg + remainder;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg  <= res_next;
        flag_reg <= flag_next;
        if (out_load)
        begin
            out_value_reg <= res_reg;
            out_flag_reg  <= flag_reg;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.value     = out_value_reg;
    assign rsp.zero_span = out_flag_reg;

    ap_idle_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> !rem_st.busy) else $error("request taken while dividing");
    ap_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        rem_st.done |-> (state_reg == S_DIV)) else $error("remainder done outside divide");
    ap_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != S_IDLE)) else $error("accepted request left no work");
    ap_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> rsp.valid) else $error("result loaded but not presented");

endmodule
